// ===== hw/rtl/drs_pkg.sv =====
// drs_pkg: shared types and codes for the disk request scheduler
// queue entry layout, command and policy codes, sequencer state encoding
// no dependencies
`timescale 1ns / 1ps

package drs_pkg;

    // one queued or current request
    typedef struct packed {
        logic [31:0] arr_time;
        logic [15:0] cyl;
        logic [15:0] id;
    } entry_t;

    // request kind carried on tuser
    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_DONE   = 1'b1;

    // selection policy register codes
    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SSTF = 2'd1;
    localparam logic [1:0] POL_LOOK = 2'd2;

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_SHIFT  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

endpackage

// ===== hw/rtl/disk_request_scheduler.sv =====
// Flow: an arrival passes from accept through the finish state, which waits for a free
// output register. A completion runs its scan passes, then compacts from k, the chosen slot,
// to the youngest entry: one scan pass for shortest seek, one or two for LOOK, none for FCFS.
// One queue read port (one read a cycle) and a shared distance/key comparator pace each pass.
// One request at a time; the next is taken once the result sits in the output register.
// Reset: pending count, current request, policy and control clear; queue memory is not reset.
`timescale 1ns / 1ps

module disk_request_scheduler #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: policy register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,      // policy
    // request input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,       // req_id, cylinder, arrival_time, head_cylinder, scan_up
    input  logic        s_tuser,       // cmd
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,       // out_id, out_cylinder, out_time
    output logic        m_tuser        // dropped
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // state and registers
    drs_pkg::state_t   state_reg, state_next;
    logic [1:0]        policy_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    drs_pkg::entry_t   cur_reg, cur_next;
    logic              drop_reg, drop_next;
    logic [15:0]       head_reg, head_next;
    logic              up_reg, up_next;
    logic              look_reg, look_next;
    logic              pass2_reg, pass2_next;
    logic [IDX_W-1:0]  iss_reg, iss_next;
    logic              iss_on_reg, iss_on_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [47:0]       best_key_reg, best_key_next;
    logic [IDX_W-1:0]  sel_reg, sel_next;
    drs_pkg::entry_t   out_reg, out_next;
    logic              out_drop_reg, out_drop_next;
    logic              m_valid_reg, m_valid_next;

    // queue memory
    drs_pkg::entry_t   mem [QUEUE_DEPTH];
    drs_pkg::entry_t   rdata_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [IDX_W-1:0]  mem_raddr;
    drs_pkg::entry_t   mem_wdata;

    // input fields
    logic              in_cmd;
    drs_pkg::entry_t   in_entry;
    logic [15:0]       in_head;
    logic              in_up;
    logic              s_acc;

    // scan datapath
    logic [IDX_W-1:0]  last_idx;
    logic              dir_up;
    logic              cand_ok;
    logic [15:0]       seek_dist;
    logic [47:0]       key;
    logic              hit;

    assign in_cmd            = s_tuser;
    assign in_entry.id       = s_tdata[15:0];
    assign in_entry.cyl      = s_tdata[31:16];
    assign in_entry.arr_time = s_tdata[63:32];
    assign in_head           = s_tdata[79:64];
    assign in_up             = s_tdata[80];

    assign s_tready  = (state_reg == drs_pkg::ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {out_reg.arr_time, out_reg.cyl, out_reg.id};
    assign m_tuser   = out_drop_reg;

    // index of the youngest queued entry
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    // shared compare unit: direction filter, seek distance and ordered key
    assign dir_up    = up_reg ^ pass2_reg;
    assign cand_ok   = !look_reg ||
                       (dir_up ? (rdata_reg.cyl >= head_reg) : (rdata_reg.cyl <= head_reg));
    assign seek_dist = (rdata_reg.cyl >= head_reg) ? (rdata_reg.cyl - head_reg)
                                                   : (head_reg - rdata_reg.cyl);
    assign key       = {seek_dist, rdata_reg.arr_time};
    assign hit       = cand_ok && (!found_reg || (key < best_key_reg));

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        cur_next      = cur_reg;
        drop_next     = drop_reg;
        head_next     = head_reg;
        up_next       = up_reg;
        look_next     = look_reg;
        pass2_next    = pass2_reg;
        iss_next      = iss_reg;
        iss_on_next   = iss_on_reg;
        rd_pend_next  = 1'b0;
        rd_idx_next   = rd_idx_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_key_next = best_key_reg;
        sel_next      = sel_reg;
        out_next      = out_reg;
        out_drop_next = out_drop_reg;
        m_valid_next  = m_valid_reg;
        mem_we        = 1'b0;
        mem_waddr     = IDX_W'(count_reg);
        mem_wdata     = in_entry;
        mem_raddr     = iss_reg;

        // result taken downstream
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        // read issue for scan and compaction
        if ((state_reg == drs_pkg::ST_SCAN || state_reg == drs_pkg::ST_SHIFT) && iss_on_reg)
        begin
            rd_pend_next = 1'b1;
            rd_idx_next  = iss_reg;
            if (iss_reg == last_idx)
            begin
                iss_on_next = 1'b0;
            end
            else
            begin
                iss_next = iss_reg + IDX_W'(1);
            end
        end

        case (state_reg)
            drs_pkg::ST_IDLE:
            begin
                if (s_acc)
                begin
                    drop_next  = 1'b0;
                    state_next = drs_pkg::ST_FINISH;
                    if (in_cmd == drs_pkg::CMD_ARRIVE)
                    begin
                        // arrival: make current, queue, or drop when full
                        if (cur_reg.id == 16'd0)
                        begin
                            cur_next = in_entry;
                        end
                        else if (count_reg < CNT_W'(QUEUE_DEPTH))
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                    end
                    else
                    begin
                        // completion: pick the next request
                        head_next = in_head;
                        up_next   = in_up;
                        if (count_reg == '0)
                        begin
                            cur_next = '0;
                        end
                        else if (policy_reg == drs_pkg::POL_SSTF ||
                                 policy_reg == drs_pkg::POL_LOOK)
                        begin
                            look_next   = (policy_reg == drs_pkg::POL_LOOK);
                            pass2_next  = 1'b0;
                            found_next  = 1'b0;
                            iss_next    = '0;
                            iss_on_next = 1'b1;
                            state_next  = drs_pkg::ST_SCAN;
                        end
                        else
                        begin
                            sel_next    = '0;
                            iss_next    = '0;
                            iss_on_next = 1'b1;
                            state_next  = drs_pkg::ST_SHIFT;
                        end
                    end
                end
            end

            drs_pkg::ST_SCAN:
            begin
                if (rd_pend_reg)
                begin
                    // keep the best candidate so far
                    if (hit)
                    begin
                        found_next    = 1'b1;
                        best_key_next = key;
                        best_idx_next = rd_idx_reg;
                    end
                    // end of pass
                    if (rd_idx_reg == last_idx)
                    begin
                        if (found_reg || hit)
                        begin
                            sel_next    = hit ? rd_idx_reg : best_idx_reg;
                            iss_next    = hit ? rd_idx_reg : best_idx_reg;
                            iss_on_next = 1'b1;
                            state_next  = drs_pkg::ST_SHIFT;
                        end
                        else if (look_reg && !pass2_reg)
                        begin
                            // nothing ahead of the head: reverse direction
                            pass2_next  = 1'b1;
                            iss_next    = '0;
                            iss_on_next = 1'b1;
                        end
                        else
                        begin
                            sel_next    = '0;
                            iss_next    = '0;
                            iss_on_next = 1'b1;
                            state_next  = drs_pkg::ST_SHIFT;
                        end
                    end
                end
            end

            drs_pkg::ST_SHIFT:
            begin
                if (rd_pend_reg)
                begin
                    // take the chosen entry, move later entries up by one
                    if (rd_idx_reg == sel_reg)
                    begin
                        cur_next = rdata_reg;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = rd_idx_reg - IDX_W'(1);
                        mem_wdata = rdata_reg;
                    end
                    if (rd_idx_reg == last_idx)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = drs_pkg::ST_FINISH;
                    end
                end
            end

            drs_pkg::ST_FINISH:
            begin
                // load the output register once it is free
                if (!m_valid_reg || m_tready)
                begin
                    out_next      = cur_reg;
                    out_drop_next = drop_reg;
                    m_valid_next  = 1'b1;
                    state_next    = drs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = drs_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= drs_pkg::ST_IDLE;
            policy_reg  <= drs_pkg::POL_FCFS;
            count_reg   <= '0;
            cur_reg     <= '0;
            iss_on_reg  <= 1'b0;
            rd_pend_reg <= 1'b0;
            found_reg   <= 1'b0;
            pass2_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cur_reg     <= cur_next;
            iss_on_reg  <= iss_on_next;
            rd_pend_reg <= rd_pend_next;
            found_reg   <= found_next;
            pass2_reg   <= pass2_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                policy_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        drop_reg     <= drop_next;
        head_reg     <= head_next;
        up_reg       <= up_next;
        look_reg     <= look_next;
        iss_reg      <= iss_next;
        rd_idx_reg   <= rd_idx_next;
        best_idx_reg <= best_idx_next;
        best_key_reg <= best_key_next;
        sel_reg      <= sel_next;
        out_reg      <= out_next;
        out_drop_reg <= out_drop_next;
    end

    // queue memory write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // queue memory read port, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[mem_raddr];
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("pending count above queue depth");

    a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == drs_pkg::ST_SHIFT || state_reg == drs_pkg::ST_SCAN) |-> count_reg != '0)
        else $error("scan or compaction with an empty queue");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == drs_pkg::ST_IDLE || state_reg == drs_pkg::ST_SHIFT))
        else $error("queue write outside arrival or compaction");

    a_remove_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == drs_pkg::ST_SHIFT && state_next == drs_pkg::ST_FINISH)
        |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("completion did not remove exactly one entry");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(m_tdata) && $stable(m_tuser)))
        else $error("waiting result changed or vanished");

endmodule
